// ----- rtl/threshold_screen_halftoner_top_defines.svh -----
// assertion macros shared by the halftoner checker
`ifndef THRESHOLD_SCREEN_HALFTONER_TOP_DEFINES_SVH
`define THRESHOLD_SCREEN_HALFTONER_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define TSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define TSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/tsh_pkg.sv -----
// types and constants of the threshold screen halftoner
package tsh_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_TONE   = 2'd1,
    OP_OFFSET = 2'd2,
    OP_LEVEL  = 2'd3
  } opcode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_START_COLUMN  = 2'd2,
    CFG_START_ROW     = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned LEVEL_DEPTH = 65536;
  localparam int unsigned OUT_LEVEL_W = 8;

  typedef struct packed {
    opcode_e       opcode;
    logic [15:0]   table_index;
    logic [15:0]   table_data;
    logic [15:0]   sample;
    logic          frame_start;
    logic          line_end;
  } in_item_t;

  typedef struct packed {
    logic [OUT_LEVEL_W-1:0] level_value;
    logic                   last_in_line;
  } out_item_t;

  // configuration register set
  typedef struct packed {
    logic [7:0] screen_width;
    logic [7:0] screen_height;
    logic [6:0] start_column;
    logic [6:0] start_row;
  } cfg_t;

  // per-pixel control from the pipeline to the screen cursor
  typedef struct packed {
    logic step;
    logic frame_start;
    logic line_end;
  } cursor_ctl_t;

endpackage

// ----- rtl/threshold_screen_halftoner_top.sv -----
// Threshold screen halftoner top level. Pixel and table-write items are
// accepted one per clock unless a waiting result stalls them. A pixel reads
// the tone table and the screen offset table at acceptance, then adds and
// clamps the two while reading the level table; its result goes through the
// level read register to the output register, and results leave in order.
// Table writes go straight into their memory and give no result. The rate
// of one item per clock is set by the single read and single write port of
// each table memory. The tables hold nothing useful until loaded and need no
// clearing pass after reset. A three-entry pipeline of valid stages with an
// output register lets new items in while a result waits to be taken.
module threshold_screen_halftoner_top import tsh_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 128,
  parameter int unsigned MAX_SCREEN_HEIGHT = 128,
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned LEVEL_BITS        = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TONE_DEPTH = 2 ** SAMPLE_BITS;
  localparam int unsigned SCR_DEPTH  = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
  localparam int unsigned SCR_AW     = $clog2(SCR_DEPTH);
  localparam int unsigned LVL_AW     = $clog2(LEVEL_DEPTH);

  cfg_t                  cfg_q;
  cursor_ctl_t           cursor_ctl;
  logic [SCR_AW-1:0]     scr_raddr;
  logic                  in_acc, pix_acc;
  logic                  mv1, mv2;
  logic                  v1_q, v2_q, vo_q;
  logic                  lend1_q, lend2_q;
  out_item_t             out_q;
  logic [VALUE_W-1:0]    tone_rd, off_rd;
  logic [LEVEL_BITS-1:0] lvl_rd;
  logic [VALUE_W:0]      sum;
  logic [LVL_AW-1:0]     lvl_raddr;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{screen_width: 8'd1, screen_height: 8'd1,
                 start_column: 7'd0, start_row: 7'd0};
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        CFG_START_COLUMN:  cfg_q.start_column  <= cfg_data_i[6:0];
        CFG_START_ROW:     cfg_q.start_row     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign mv2        = !vo_q || out_ready_i;
  assign mv1        = !v2_q || mv2;
  assign in_ready_o = !v1_q || mv1;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pix_acc    = in_acc && (in_item_i.opcode == OP_PIXEL);

  // screen cursor
  assign cursor_ctl = '{step: pix_acc, frame_start: in_item_i.frame_start,
                        line_end: in_item_i.line_end};

  tsh_cursor #(
    .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT(MAX_SCREEN_HEIGHT)
  ) u_cursor (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .ctl_i (cursor_ctl),
    .addr_o(scr_raddr)
  );

  // tone table
  tsh_ram #(.WIDTH(VALUE_W), .DEPTH(TONE_DEPTH)) u_tone_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_item_i.opcode == OP_TONE)),
    .waddr_i(in_item_i.table_index[SAMPLE_BITS-1:0]),
    .wdata_i(in_item_i.table_data),
    .re_i   (pix_acc),
    .raddr_i(in_item_i.sample[SAMPLE_BITS-1:0]),
    .rdata_o(tone_rd)
  );

  // screen offsets, out-of-range writes dropped
  tsh_ram #(.WIDTH(VALUE_W), .DEPTH(SCR_DEPTH)) u_screen_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_item_i.opcode == OP_OFFSET) &&
             (32'(in_item_i.table_index) < 32'(SCR_DEPTH))),
    .waddr_i(SCR_AW'(in_item_i.table_index)),
    .wdata_i(in_item_i.table_data),
    .re_i   (pix_acc),
    .raddr_i(scr_raddr),
    .rdata_o(off_rd)
  );

  // sum with saturation selects the level entry
  assign sum       = {1'b0, tone_rd} + {1'b0, off_rd};
  assign lvl_raddr = sum[VALUE_W] ? '1 : LVL_AW'(sum);

  // level table; a write is only taken when any waiting pixel reads now
  tsh_ram #(.WIDTH(LEVEL_BITS), .DEPTH(LEVEL_DEPTH)) u_level_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && (in_item_i.opcode == OP_LEVEL)),
    .waddr_i(LVL_AW'(in_item_i.table_index)),
    .wdata_i(in_item_i.table_data[LEVEL_BITS-1:0]),
    .re_i   (v1_q && mv1),
    .raddr_i(lvl_raddr),
    .rdata_o(lvl_rd)
  );

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= pix_acc;
      end
      if (mv1) begin
        v2_q <= v1_q;
      end
      if (mv2) begin
        vo_q <= v2_q;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      lend1_q <= in_item_i.line_end;
    end
    if (mv1 && v1_q) begin
      lend2_q <= lend1_q;
    end
    if (mv2 && v2_q) begin
      out_q.level_value  <= OUT_LEVEL_W'(lvl_rd);
      out_q.last_in_line <= lend2_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/tsh_ram.sv -----
// generic simple dual-port ram with registered read
module tsh_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tsh_cursor.sv -----
// screen cell cursor: column and row counters and offset address
module tsh_cursor import tsh_pkg::*; #(
  parameter int unsigned MAX_SCREEN_WIDTH  = 128,
  parameter int unsigned MAX_SCREEN_HEIGHT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cursor_ctl_t         ctl_i,
  output logic [$clog2(MAX_SCREEN_WIDTH*MAX_SCREEN_HEIGHT)-1:0] addr_o
);

  localparam int unsigned CW  = $clog2(MAX_SCREEN_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_SCREEN_HEIGHT);
  localparam int unsigned WSW = $clog2(MAX_SCREEN_WIDTH + 1);
  localparam int unsigned HSW = $clog2(MAX_SCREEN_HEIGHT + 1);
  localparam int unsigned AW  = $clog2(MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT);

  logic [CW-1:0]  col_q, col_d, cur_col, rd_col, start_col;
  logic [RW-1:0]  row_q, row_d, cur_row, rd_row, start_row;
  logic [WSW-1:0] eff_w;
  logic [HSW-1:0] eff_h;

  // effective tile size: zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (cfg_i.screen_width == '0) begin
      eff_w = WSW'(1);
    end else if (32'(cfg_i.screen_width) > 32'(MAX_SCREEN_WIDTH)) begin
      eff_w = WSW'(MAX_SCREEN_WIDTH);
    end else begin
      eff_w = WSW'(cfg_i.screen_width);
    end
    if (cfg_i.screen_height == '0) begin
      eff_h = HSW'(1);
    end else if (32'(cfg_i.screen_height) > 32'(MAX_SCREEN_HEIGHT)) begin
      eff_h = HSW'(MAX_SCREEN_HEIGHT);
    end else begin
      eff_h = HSW'(cfg_i.screen_height);
    end
  end

  // start positions clamped into the tile
  assign start_col = (32'(cfg_i.start_column) >= 32'(eff_w)) ?
                     CW'(eff_w - WSW'(1)) : CW'(cfg_i.start_column);
  assign start_row = (32'(cfg_i.start_row) >= 32'(eff_h)) ?
                     RW'(eff_h - HSW'(1)) : RW'(cfg_i.start_row);

  // frame start loads the counters before the pixel is screened
  assign cur_col = ctl_i.frame_start ? start_col : col_q;
  assign cur_row = ctl_i.frame_start ? start_row : row_q;

  // counters left beyond a shrunken tile read the last cell
  assign rd_col = (32'(cur_col) >= 32'(eff_w)) ? CW'(eff_w - WSW'(1)) : cur_col;
  assign rd_row = (32'(cur_row) >= 32'(eff_h)) ? RW'(eff_h - HSW'(1)) : cur_row;

  assign addr_o = AW'(rd_row) * AW'(MAX_SCREEN_WIDTH) + AW'(rd_col);

  // advance after the pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (ctl_i.step) begin
      if (ctl_i.line_end) begin
        col_d = start_col;
        row_d = (32'(cur_row) + 32'd1 >= 32'(eff_h)) ? '0 : RW'(cur_row + RW'(1));
      end else begin
        col_d = (32'(cur_col) + 32'd1 >= 32'(eff_w)) ? '0 : CW'(cur_col + CW'(1));
        row_d = cur_row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- rtl/tsh_checker.sv -----
// port-level assertions for the halftoner and their bind
`include "threshold_screen_halftoner_top_defines.svh"

module tsh_checker import tsh_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // no result while reset is held
  `TSH_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "result during reset")

  // a result that is not taken stays offered
  `TSH_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  // a result that is not taken keeps its payload
  `TSH_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_item_o), "result changed")

  // a fresh result comes from a pixel taken earlier, through stage one, stage two and the output register
  `TSH_ASSERT(a_out_latency, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && (in_item_i.opcode == OP_PIXEL), 3), "result without pixel")

endmodule

bind threshold_screen_halftoner_top tsh_checker u_tsh_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
